[rtl/assert_macros.svh]
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MWF_ASSERT(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");
`define MWF_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define MWF_ASSERT(lbl, clk, rst_n, expr)
`define MWF_IMPLY(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/mwf_pkg.sv]
// Shared constants and types of the median window filter.
package mwf_pkg;
	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int MAX_WINDOW_DEF = 9;
	localparam int PIXEL_BITS_DEF = 10;
	localparam int MAX_HEIGHT     = 4096;
	localparam int FW_BITS  = 12;
	localparam int FH_BITS  = 13;
	localparam int WS_BITS  = 4;
	localparam int CFG_DW   = 13;
	localparam int CFG_IW   = 2;
	localparam logic [CFG_IW-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_WINDOW_SIZE  = 2'd2;
	localparam logic [1:0] CLS_LOW  = 2'd0;
	localparam logic [1:0] CLS_REAL = 2'd1;
	localparam logic [1:0] CLS_HIGH = 2'd2;
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_LAST = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;
endpackage

[rtl/mwf_ram.sv]
// Generic simple dual-port RAM with registered read.
module mwf_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[rtl/median_window_filter_unit.sv]
// Top level of the streaming 2-D median window filter.
// Pixels of one frame enter in raster order; each request yields at most one filtered
// pixel, in raster order, delayed by half a window in rows and columns; drain requests
// flush the tail. An item that releases a pixel stalls the input while the unit steps
// through its scan, last and finish states; for an interior pixel the single read port
// of the line store feeds one window value per cycle into a sorting register row.
// A write to any of the three registers restarts the frame; the input stalls while
// a write is in progress.
module median_window_filter_unit #(
	parameter int MAX_WIDTH  = mwf_pkg::MAX_WIDTH_DEF,
	parameter int MAX_WINDOW = mwf_pkg::MAX_WINDOW_DEF,
	parameter int PIXEL_BITS = mwf_pkg::PIXEL_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          kind,
	input  logic signed [PIXEL_BITS-1:0]  pixel_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [PIXEL_BITS-1:0]  pixel_out,
	output logic                          frame_end,
	input  logic                          cfg_we,
	input  logic [mwf_pkg::CFG_IW-1:0]    cfg_index,
	input  logic [mwf_pkg::CFG_DW-1:0]    cfg_data
);
	import mwf_pkg::*;
	`include "assert_macros.svh"

	localparam int DEPTH = (MAX_WINDOW - 1) * MAX_WIDTH + MAX_WINDOW;
	localparam int AW    = $clog2(DEPTH);
	localparam int WN    = (MAX_WINDOW % 2 == 1) ? MAX_WINDOW : MAX_WINDOW - 1;
	localparam int WC    = WN * WN;
	localparam int MID   = WC / 2;
	localparam int KW    = PIXEL_BITS + 2;
	localparam int NW    = $clog2(WC + 1);
	localparam int CW    = 24;
	localparam logic [PIXEL_BITS-1:0] SIGN = {1'b1, {(PIXEL_BITS-1){1'b0}}};

	logic [FW_BITS-1:0] fw_q;
	logic [FH_BITS-1:0] fh_q;
	logic [WS_BITS-1:0] ws_q;

	logic [FW_BITS-1:0] ew;
	logic [FH_BITS-1:0] eh;
	logic [WS_BITS-1:0] en, en_sat, hh;
	logic [NW-1:0]      nn, pad_lo;
	logic [AW:0]        delay, row_step;

	always_comb begin
		ew = fw_q;
		if (fw_q == '0) ew = FW_BITS'(1);
		else if (32'(fw_q) > MAX_WIDTH) ew = FW_BITS'(MAX_WIDTH);
		eh = fh_q;
		if (fh_q == '0) eh = FH_BITS'(1);
		else if (32'(fh_q) > MAX_HEIGHT) eh = FH_BITS'(MAX_HEIGHT);
		en_sat = (32'(ws_q) > MAX_WINDOW) ? WS_BITS'(MAX_WINDOW) : ws_q;
		en = en_sat;
		if (!en_sat[0]) en = (en_sat == '0) ? WS_BITS'(1) : en_sat - WS_BITS'(1);
		hh = en >> 1;
		nn = NW'(en) * NW'(en);
		pad_lo = NW'((NW'(WC) - nn) >> 1);
		delay = (AW+1)'(hh) * (AW+1)'(ew) + (AW+1)'(hh);
		row_step = (AW+1)'(ew) + (AW+1)'(1) - (AW+1)'(en);
	end

	state_t state_q;
	logic [FW_BITS-1:0] in_col_q, out_col_q;
	logic [FH_BITS-1:0] in_row_q, out_row_q;
	logic [CW-1:0]      rcv_q, ocnt_q;
	logic               full_q;
	logic [AW-1:0]      wr_addr_q, out_addr_q, rd_addr_q;
	logic [WS_BITS-1:0] dc_q;
	logic [NW-1:0]      left_q;
	logic               border_q, fe_q, rd_s1;
	logic [PIXEL_BITS-1:0] res_q;
	logic [KW-1:0]      key_q [WC];
	logic               out_valid_q, frame_end_q;
	logic [PIXEL_BITS-1:0] pixel_out_q;

	logic accept, wr_en, full_n, emit, is_border, is_fe;
	logic [FW_BITS-1:0] in_col_n;
	logic [FH_BITS-1:0] in_row_n;
	logic [CW-1:0]      rcv_n;
	logic [AW:0]        base_sum, base, step_sum, next_addr;
	logic [PIXEL_BITS-1:0] rdata;
	logic [KW-1:0]      vkey;
	logic [WC-1:0]      gt;
	logic               out_free;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE) || cfg_we;
	assign wr_en = accept && !kind && !full_q;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		in_col_n = in_col_q;
		in_row_n = in_row_q;
		full_n = full_q;
		rcv_n = rcv_q;
		if (wr_en) begin
			rcv_n = rcv_q + CW'(1);
			if (in_col_q + FW_BITS'(1) >= ew) begin
				in_col_n = '0;
				if (in_row_q + FH_BITS'(1) >= eh) begin
					in_row_n = '0;
					full_n = 1'b1;
				end else begin
					in_row_n = in_row_q + FH_BITS'(1);
				end
			end else begin
				in_col_n = in_col_q + FW_BITS'(1);
			end
		end
		emit = full_n || (rcv_n > CW'(delay) + ocnt_q);
		is_border = (out_row_q < FH_BITS'(hh))
			|| ((FH_BITS+1)'(out_row_q) + (FH_BITS+1)'(hh) >= (FH_BITS+1)'(eh))
			|| (out_col_q < FW_BITS'(hh))
			|| ((FW_BITS+1)'(out_col_q) + (FW_BITS+1)'(hh) >= (FW_BITS+1)'(ew));
		is_fe = (out_row_q == eh - FH_BITS'(1)) && (out_col_q == ew - FW_BITS'(1));
		base_sum = (AW+1)'(out_addr_q) + (AW+1)'(DEPTH) - delay;
		base = (base_sum >= (AW+1)'(DEPTH)) ? base_sum - (AW+1)'(DEPTH) : base_sum;
		step_sum = (AW+1)'(rd_addr_q)
			+ ((dc_q == en - WS_BITS'(1)) ? row_step : (AW+1)'(1));
		next_addr = (step_sum >= (AW+1)'(DEPTH)) ? step_sum - (AW+1)'(DEPTH) : step_sum;
	end

	mwf_ram #(.WIDTH(PIXEL_BITS), .DEPTH(DEPTH)) u_line (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr_q),
		.wdata (pixel_in),
		.re    (state_q == S_SCAN),
		.raddr (rd_addr_q),
		.rdata (rdata)
	);

	assign vkey = {CLS_REAL, rdata ^ SIGN};

	always_comb begin
		for (int k = 0; k < WC; k++) begin
			gt[k] = key_q[k] > vkey;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			for (int k = 0; k < WC; k++) begin
				key_q[k] <= (NW'(k) < pad_lo) ? {CLS_LOW, {PIXEL_BITS{1'b0}}}
					: {CLS_HIGH, {PIXEL_BITS{1'b0}}};
			end
		end else if (rd_s1 && !border_q) begin
			for (int k = 0; k < WC; k++) begin
				if (gt[k]) begin
					if (k == 0) key_q[k] <= vkey;
					else key_q[k] <= gt[(k == 0) ? 0 : k-1] ? key_q[(k == 0) ? 0 : k-1] : vkey;
				end
			end
		end
		if (state_q == S_LAST && border_q) begin
			res_q <= rdata;
		end
		if (accept && emit) begin
			border_q <= is_border;
			fe_q <= is_fe;
		end
		if (state_q == S_FIN && out_free) begin
			pixel_out_q <= border_q ? res_q : (key_q[MID][PIXEL_BITS-1:0] ^ SIGN);
			frame_end_q <= fe_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= FW_BITS'(640);
			fh_q <= FH_BITS'(480);
			ws_q <= WS_BITS'(3);
			state_q <= S_IDLE;
			in_col_q <= '0;
			in_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			rcv_q <= '0;
			ocnt_q <= '0;
			full_q <= 1'b0;
			wr_addr_q <= '0;
			out_addr_q <= '0;
			rd_addr_q <= '0;
			dc_q <= '0;
			left_q <= '0;
			rd_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			rd_s1 <= (state_q == S_SCAN);
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_FRAME_WIDTH:  fw_q <= cfg_data[FW_BITS-1:0];
					CFG_FRAME_HEIGHT: fh_q <= cfg_data[FH_BITS-1:0];
					CFG_WINDOW_SIZE:  ws_q <= cfg_data[WS_BITS-1:0];
					default: ;
				endcase
				if (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT
						|| cfg_index == CFG_WINDOW_SIZE) begin
					in_col_q <= '0;
					in_row_q <= '0;
					out_col_q <= '0;
					out_row_q <= '0;
					rcv_q <= '0;
					ocnt_q <= '0;
					full_q <= 1'b0;
					wr_addr_q <= '0;
					out_addr_q <= '0;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (emit) begin
							state_q <= S_SCAN;
							rd_addr_q <= is_border ? out_addr_q : base[AW-1:0];
							dc_q <= '0;
							left_q <= is_border ? NW'(1) : nn;
						end
						if (emit && is_fe) begin
							in_col_q <= '0;
							in_row_q <= '0;
							out_col_q <= '0;
							out_row_q <= '0;
							rcv_q <= '0;
							ocnt_q <= '0;
							full_q <= 1'b0;
							wr_addr_q <= '0;
							out_addr_q <= '0;
						end else begin
							in_col_q <= in_col_n;
							in_row_q <= in_row_n;
							full_q <= full_n;
							rcv_q <= rcv_n;
							if (wr_en) begin
								wr_addr_q <= (32'(wr_addr_q) == DEPTH - 1) ? '0
									: wr_addr_q + AW'(1);
							end
							if (emit) begin
								ocnt_q <= ocnt_q + CW'(1);
								out_addr_q <= (32'(out_addr_q) == DEPTH - 1) ? '0
									: out_addr_q + AW'(1);
								if (out_col_q == ew - FW_BITS'(1)) begin
									out_col_q <= '0;
									out_row_q <= out_row_q + FH_BITS'(1);
								end else begin
									out_col_q <= out_col_q + FW_BITS'(1);
								end
							end
						end
					end
				end
				S_SCAN: begin
					rd_addr_q <= next_addr[AW-1:0];
					dc_q <= (dc_q == en - WS_BITS'(1)) ? '0 : dc_q + WS_BITS'(1);
					left_q <= left_q - NW'(1);
					if (left_q == NW'(1)) state_q <= S_LAST;
				end
				S_LAST: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_out = pixel_out_q;
	assign frame_end = frame_end_q;

	`MWF_ASSERT(a_addr_range, clk, arst_n,
		(32'(wr_addr_q) < DEPTH) && (32'(out_addr_q) < DEPTH))
	`MWF_ASSERT(a_fin_no_insert, clk, arst_n, !(state_q == S_FIN && rd_s1))
	`MWF_IMPLY(a_emit_scan, clk, arst_n, accept && emit, state_q == S_SCAN)
	`MWF_ASSERT(a_out_behind_in, clk, arst_n, ocnt_q <= rcv_q)
endmodule
